/* hdl/mchd_pkg.sv */
package mchd_pkg;

	localparam int KIND_W   = 2;
	localparam int TIME_W   = 32;
	localparam int LIMIT_W  = 20;
	localparam int COUNT_W  = 8;
	localparam int TRIG_W   = 2;
	localparam int CFG_IDX_W = 1;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_OTHER   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	// trigger codes
	localparam logic [TRIG_W-1:0] TRIG_NONE     = 2'd0;
	localparam logic [TRIG_W-1:0] TRIG_CLICK    = 2'd1;
	localparam logic [TRIG_W-1:0] TRIG_HOLD_ON  = 2'd2;
	localparam logic [TRIG_W-1:0] TRIG_HOLD_OFF = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MULTI_LIMIT = 1'd1;

	localparam logic [LIMIT_W-1:0] CLICK_LIMIT_RST = 20'd150000;
	localparam logic [LIMIT_W-1:0] MULTI_LIMIT_RST = 20'd400000;

	typedef struct packed {
		logic [TRIG_W-1:0]  trigger_kind;
		logic [COUNT_W-1:0] click_count;
	} mchd_result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] press_count;
		logic [TIME_W-1:0]  last_press_time;
		logic               click_seen;
		logic               hold_sent;
		mchd_result_t       held;
	} mchd_state_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] click_limit_us;
		logic [LIMIT_W-1:0] multi_limit_us;
	} mchd_limits_t;

endpackage

/* hdl/mchd_if.sv */
interface mchd_evt_if import mchd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [TIME_W-1:0] time_us;

	modport source (output valid, output kind, output time_us, input ready);
	modport sink (input valid, input kind, input time_us, output ready);
endinterface

interface mchd_res_if import mchd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TRIG_W-1:0]  trigger_kind;
	logic [COUNT_W-1:0] click_count;

	modport source (output valid, output trigger_kind, output click_count, input ready);
	modport sink (input valid, input trigger_kind, input click_count, output ready);
endinterface

/* hdl/multi_click_hold_detector_unit.sv */
// Channel | Dir | Payload                      | Handshake
// evt     | in  | kind[1:0], time_us[31:0]     | valid/ready
// res     | out | trigger_kind[1:0], click_count[7:0] | valid/ready
// cfg     | in  | cfg_index, cfg_wdata[19:0]   | cfg_we, no back-pressure
//
// One result item per event item; an accepted event passes the event stage, then the result register.
// Sustained rate is one item per cycle while res.ready stays high; the detector state updates in one pass.
// arst_n clears the state registers and loads the default limits.
// A stalled result holds the event stage; evt.ready drops only when both are full.
module multi_click_hold_detector_unit import mchd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	mchd_evt_if.sink             evt,
	mchd_res_if.source           res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_wdata
);

	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [TIME_W-1:0] time_s1;
	logic              res_valid_q;
	mchd_result_t      res_q;
	mchd_limits_t      limits_q;
	mchd_result_t      step_res;
	mchd_state_t       state;
	logic              advance;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q <= '{CLICK_LIMIT_RST, MULTI_LIMIT_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLICK_LIMIT: limits_q.click_limit_us <= cfg_wdata;
				REG_MULTI_LIMIT: limits_q.multi_limit_us <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_s1 <= evt.kind;
			time_s1 <= evt.time_us;
		end
	end

	mchd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.kind    (kind_s1),
		.time_us (time_s1),
		.limits  (limits_q),
		.result  (step_res),
		.state   (state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= step_res;
	end

	assign res.valid        = res_valid_q;
	assign res.trigger_kind = res_q.trigger_kind;
	assign res.click_count  = res_q.click_count;

	a_none_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.trigger_kind == TRIG_NONE) |-> res_q.click_count == '0)
		else $error("no-trigger result carries a nonzero count");

	a_click_needs_presses: assert property (@(posedge clk) disable iff (!arst_n)
		state.click_seen |-> state.press_count != '0)
		else $error("click pending with an empty press series");

	a_hold_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (step_res.trigger_kind == TRIG_HOLD_OFF) |=> state.press_count == '0)
		else $error("press series survives a hold end");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("processed item did not reach the result register");

endmodule

/* hdl/mchd_core.sv */
module mchd_core import mchd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [KIND_W-1:0]  kind,
	input  logic [TIME_W-1:0]  time_us,
	input  mchd_limits_t       limits,
	output mchd_result_t       result,
	output mchd_state_t        state
);

	mchd_state_t state_q;
	mchd_state_t nxt;
	logic        press;
	logic        release_evt;
	logic [TIME_W-1:0] dt;
	logic        in_click;
	logic        in_multi;

	assign press       = (kind == KIND_PRESS);
	assign release_evt = (kind == KIND_RELEASE);

	always_comb begin
		nxt = state_q;
		if (press) begin
			nxt.last_press_time = time_us;
			nxt.press_count     = state_q.press_count + COUNT_W'(1);
			nxt.held            = '{TRIG_NONE, '0};
			nxt.click_seen      = 1'b0;
		end

		dt       = time_us - nxt.last_press_time;
		in_click = dt < TIME_W'(limits.click_limit_us);
		in_multi = dt < TIME_W'(limits.multi_limit_us);

		if (nxt.press_count != '0) begin
			priority if (in_click) begin
				if (release_evt)
					nxt.click_seen = 1'b1;
			end else if (in_multi) begin
				if (!nxt.click_seen) begin
					if (!nxt.hold_sent) begin
						nxt.held      = '{TRIG_HOLD_ON, nxt.press_count};
						nxt.hold_sent = 1'b1;
					end else begin
						nxt.held = '{TRIG_NONE, '0};
					end
					if (release_evt) begin
						nxt.held        = '{TRIG_HOLD_OFF, nxt.press_count};
						nxt.press_count = '0;
						nxt.hold_sent   = 1'b0;
					end
				end
			end else begin
				// late window: report a pending click series, a release ends the hold
				if (nxt.click_seen) begin
					nxt.held        = '{TRIG_CLICK, nxt.press_count};
					nxt.click_seen  = 1'b0;
					nxt.press_count = '0;
				end
				if (release_evt) begin
					nxt.held        = '{TRIG_HOLD_OFF, nxt.press_count};
					nxt.press_count = '0;
					nxt.hold_sent   = 1'b0;
				end
			end
		end else begin
			nxt.held = '{TRIG_NONE, '0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= nxt;
		end
	end

	assign result = nxt.held;
	assign state  = state_q;

endmodule
